// File: hdl/csq_pkg.sv
// Shared types, widths and constants for the carrier squelch core.
`default_nettype none

package csq_pkg;

  // field and state widths
  localparam int LVL_W  = 12;
  localparam int DUR_W  = 16;
  localparam int TIME_W = 32;
  localparam int SU_W   = 17;
  localparam int WIN_W  = 20;
  localparam int SUM_W  = 28;
  localparam int CNT_W  = 16;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 2;
  localparam int STAT_W = 2;
  localparam int MODE_W = 2;

  // serial divider: dividend is |2*sum + cnt|, plus 2*cnt - 1 when negative (< 2^29 + 2^17), divisor 2*cnt
  localparam int DIV_DW = 30;
  localparam int DIV_VW = CNT_W + 1;
  localparam int QUO_W  = 13;

  localparam logic [SU_W-1:0]  STARTUP_US = 17'd100000;
  localparam logic [WIN_W-1:0] WINDOW_US  = 20'd500000;
  localparam logic [CNT_W-1:0] COUNT_MAX  = 16'hFFFF;

  // threshold offset of 10 dB, and 5 * (10 dB + 0.1 dB) for the exact update test
  localparam logic signed [QUO_W-1:0] OFFSET_Q4 = 13'sd160;
  localparam logic signed [15:0]      HYST_X5   = 16'sd808;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_PRESET = 2'd1;
  localparam logic [IDX_W-1:0] CFG_MUTE   = 2'd2;
  localparam logic [IDX_W-1:0] CFG_LOSS   = 2'd3;

  // squelch modes; bit 1 set means squelch off
  localparam logic [MODE_W-1:0] MODE_PRESET = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd1;

  // result codes
  localparam logic [STAT_W-1:0] STAT_OPEN = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MUTE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_LOSS = 2'd2;

  // reset values of the registers
  localparam logic [MODE_W-1:0]       MODE_RST   = MODE_PRESET;
  localparam logic signed [LVL_W-1:0] PRESET_RST = -12'sd960;
  localparam logic [TIME_W-1:0]       MUTE_RST   = 32'd100000;
  localparam logic [TIME_W-1:0]       LOSS_RST   = 32'd1000000;

  typedef struct packed {
    logic signed [LVL_W-1:0] rf_level;
    logic [DUR_W-1:0]        chunk_duration;
  } csq_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]       squelch_status;
    logic signed [LVL_W-1:0] threshold_now;
  } csq_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } csq_div_stat_t;

endpackage

`default_nettype wire

// File: hdl/csq_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
`default_nettype none

module csq_div #(
  parameter int DW = 30,
  parameter int VW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output csq_pkg::csq_div_stat_t stat,
  output logic [DW-1:0]      quotient
);
  import csq_pkg::*;

  localparam int CW = $clog2(DW);

  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [CW-1:0] step;
  logic          busy;
  logic          done;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;
  logic          fits;

  always_comb begin
    rem_sh  = {rem, quotient[DW-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    fits    = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= CW'(DW - 1);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
        quotient <= {quotient[DW-2:0], fits};
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// File: hdl/carrier_squelch_with_loss_core.sv
// Carrier squelch with start-up delay, auto noise-floor threshold and carrier-loss report.
//
// One chunk (RF level, duration) in, one result (open/mute/loss plus the
// threshold in use) out. The core takes one chunk at a time and holds stall
// high while a chunk is being worked. Squelch off and the 100 ms start-up
// delay take the shortest path, preset mode a longer one, and auto mode,
// which also feeds the averaging window, the longest; the chunk that closes
// a window and lowers the threshold also waits on the 30-step serial
// divider that forms the window mean. A finished result sits in the output
// register, so the next chunk is taken while it waits. Configuration writes
// land at once and are meant for idle time only.
`default_nettype none

module carrier_squelch_with_loss_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire csq_pkg::csq_in_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output csq_pkg::csq_out_t              out_data,
  input  wire logic                      cfg_we,
  input  wire logic [csq_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [csq_pkg::CFG_W-1:0] cfg_wdata
);
  import csq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WIN,
    S_CHK,
    S_MUL,
    S_CMP,
    S_DIV,
    S_WEAK,
    S_MUTE,
    S_FIN
  } state_t;

  state_t state;

  // configuration
  logic [MODE_W-1:0]       squelch_mode;
  logic signed [LVL_W-1:0] preset_threshold;
  logic [TIME_W-1:0]       mute_delay;
  logic [TIME_W-1:0]       loss_delay;

  // squelch state
  logic [SU_W-1:0]         startup_elapsed;
  logic [WIN_W-1:0]        window_elapsed;
  logic signed [SUM_W-1:0] level_sum;
  logic [CNT_W-1:0]        level_count;
  logic signed [LVL_W-1:0] active_threshold;
  logic [TIME_W-1:0]       weak_timer;
  logic                    muted;
  logic [TIME_W-1:0]       muted_timer;
  logic                    lost;

  // working registers
  logic signed [LVL_W-1:0] lvl;
  logic [DUR_W-1:0]        dur;
  logic signed [32:0]      prod;
  logic signed [30:0]      num;
  logic [STAT_W-1:0]       res_status;
  logic signed [LVL_W-1:0] res_thr;

  // combinational terms
  logic [SU_W:0]            su_sum;
  logic [SU_W-1:0]          su_sat;
  logic signed [15:0]       thr16;
  logic signed [15:0]       thr_x5;
  logic signed [32:0]       sum33;
  logic signed [32:0]       sum_x5;
  logic signed [30:0]       num_next;
  logic [30:0]              mag;
  logic                     less;
  logic                     div_start;
  logic [QUO_W-1:0]         q13;
  logic signed [QUO_W-1:0]  mean_q;
  logic signed [QUO_W-1:0]  new_thr;
  logic                     lvl_ge;
  logic [TIME_W:0]          w_add;
  logic [TIME_W:0]          m_add;
  logic                     m_sat;
  logic signed [LVL_W-1:0]  cfg_preset;
  csq_div_stat_t            div_stat;
  logic [DIV_DW-1:0]        div_q;

  always_comb begin
    su_sum   = {1'b0, startup_elapsed} + (SU_W + 1)'(in_data.chunk_duration);
    su_sat   = (su_sum >= {1'b0, STARTUP_US}) ? STARTUP_US : su_sum[SU_W-1:0];
    thr16    = {{(16 - LVL_W){active_threshold[LVL_W-1]}}, active_threshold};
    thr_x5   = (thr16 <<< 2) + thr16 - HYST_X5;
    sum33    = {{(33 - SUM_W){level_sum[SUM_W-1]}}, level_sum};
    sum_x5   = (sum33 <<< 2) + sum33;
    num_next = ({{(31 - SUM_W){level_sum[SUM_W-1]}}, level_sum} <<< 1)
               + $signed({15'd0, level_count});
    // floor division of a negative numerator: divide |n| + d - 1 and negate
    mag      = num[30] ? (31'(-num) + 31'({level_count, 1'b0}) - 31'd1) : num;
    less     = (sum_x5 < prod);
    div_start = (state == S_CMP) && less;
    q13      = div_q[QUO_W-1:0];
    mean_q   = num[30] ? -$signed(q13) : $signed(q13);
    new_thr  = mean_q + OFFSET_Q4;
    lvl_ge   = (lvl >= active_threshold);
    w_add    = {1'b0, weak_timer} + (TIME_W + 1)'(dur);
    m_add    = {1'b0, muted_timer} + (TIME_W + 1)'(dur);
    m_sat    = (m_add >= {1'b0, loss_delay});
    cfg_preset = cfg_wdata[LVL_W-1:0];
  end

  assign in_stall = (state != S_IDLE);

  csq_div #(
    .DW(DIV_DW),
    .VW(DIV_VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag[DIV_DW-1:0]),
    .divisor  ({level_count, 1'b0}),
    .stat     (div_stat),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      squelch_mode     <= MODE_RST;
      preset_threshold <= PRESET_RST;
      mute_delay       <= MUTE_RST;
      loss_delay       <= LOSS_RST;
      startup_elapsed  <= '0;
      window_elapsed   <= '0;
      level_sum        <= '0;
      level_count      <= '0;
      active_threshold <= PRESET_RST;
      weak_timer       <= MUTE_RST;
      muted            <= 1'b1;
      muted_timer      <= '0;
      lost             <= 1'b1;
    end else begin
      // in S_FIN the output load below decides out_valid
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            lvl <= in_data.rf_level;
            dur <= in_data.chunk_duration;
            if (squelch_mode[1]) begin
              res_status <= STAT_OPEN;
              res_thr    <= '0;
              state      <= S_FIN;
            end else begin
              startup_elapsed <= su_sat;
              if (su_sat < STARTUP_US) begin
                res_status <= STAT_MUTE;
                res_thr    <= active_threshold;
                state      <= S_FIN;
              end else if (squelch_mode == MODE_AUTO) begin
                state <= S_WIN;
              end else begin
                state <= S_WEAK;
              end
            end
          end
        end

        S_WIN: begin
          window_elapsed <= window_elapsed + WIN_W'(dur);
          if (level_count != COUNT_MAX) begin
            level_sum   <= level_sum + {{(SUM_W - LVL_W){lvl[LVL_W-1]}}, lvl};
            level_count <= level_count + 1'b1;
          end
          state <= S_CHK;
        end

        S_CHK: begin
          if (window_elapsed >= WINDOW_US) begin
            if (level_count != '0) begin
              state <= S_MUL;
            end else begin
              window_elapsed <= '0;
              level_sum      <= '0;
              state          <= S_WEAK;
            end
          end else begin
            state <= S_WEAK;
          end
        end

        S_MUL: begin
          prod  <= $signed({1'b0, level_count}) * thr_x5;
          num   <= num_next;
          state <= S_CMP;
        end

        S_CMP: begin
          if (less) begin
            state <= S_DIV;
          end else begin
            window_elapsed <= '0;
            level_sum      <= '0;
            level_count    <= '0;
            state          <= S_WEAK;
          end
        end

        S_DIV: begin
          if (div_stat.done) begin
            active_threshold <= new_thr[LVL_W-1:0];
            window_elapsed   <= '0;
            level_sum        <= '0;
            level_count      <= '0;
            state            <= S_WEAK;
          end
        end

        S_WEAK: begin
          if (lvl_ge) begin
            if ({16'd0, dur} >= weak_timer) begin
              weak_timer <= '0;
              muted      <= 1'b0;
            end else begin
              weak_timer <= weak_timer - TIME_W'(dur);
            end
          end else if (w_add >= {1'b0, mute_delay}) begin
            muted      <= 1'b1;
            weak_timer <= mute_delay;
          end else begin
            weak_timer <= w_add[TIME_W-1:0];
          end
          state <= S_MUTE;
        end

        S_MUTE: begin
          res_thr <= active_threshold;
          if (muted) begin
            muted_timer <= m_sat ? loss_delay : m_add[TIME_W-1:0];
            if (m_sat && !lost) begin
              lost       <= 1'b1;
              res_status <= STAT_LOSS;
            end else begin
              res_status <= STAT_MUTE;
            end
          end else begin
            lost        <= 1'b0;
            muted_timer <= '0;
            res_status  <= STAT_OPEN;
          end
          state <= S_FIN;
        end

        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid              <= 1'b1;
            out_data.squelch_status <= res_status;
            out_data.threshold_now  <= res_thr;
            state                  <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      // user makes register writes only while no chunk is in flight; not enforced
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE: begin
            squelch_mode     <= cfg_wdata[MODE_W-1:0];
            active_threshold <= (cfg_wdata[MODE_W-1:0] == MODE_AUTO) ? '0 : preset_threshold;
            window_elapsed   <= '0;
            level_sum        <= '0;
            level_count      <= '0;
          end
          CFG_PRESET: begin
            preset_threshold <= cfg_preset;
            if (squelch_mode != MODE_AUTO) begin
              active_threshold <= cfg_preset;
            end
          end
          CFG_MUTE: begin
            mute_delay <= cfg_wdata;
            weak_timer <= cfg_wdata;
          end
          CFG_LOSS: begin
            loss_delay <= cfg_wdata;
          end
          default: ;
        endcase
      end
    end
  end

  ap_div_start_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  ap_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider result outside divide wait");

  ap_weak_bound: assert property (@(posedge clk) disable iff (rst)
    weak_timer <= mute_delay)
    else $error("weak timer above mute time");

  ap_auto_range: assert property (@(posedge clk) disable iff (rst)
    (squelch_mode == MODE_AUTO) |->
      (active_threshold <= 12'sd0) && (active_threshold >= -12'sd1888))
    else $error("auto threshold out of range");

  ap_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("beat accepted but core not busy");

endmodule

`default_nettype wire
